@@ rtl/fbfl_pkg.sv @@
// Shared types and constants for the fixed-size block free-list allocator.
// Used by fbfl_ctrl, fbfl_dp and the top level; depends on nothing.
package fbfl_pkg;

  // Fixed field widths
  localparam int IDX_W  = 6;   // block index
  localparam int CNT_W  = 7;   // free count, blocks_in_use
  localparam int BB_W   = 13;  // block_bytes
  localparam int OFS_W  = 18;  // payload offset
  localparam int CFG_IDX_W = 1;

  localparam logic [OFS_W-1:0] OFS_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_EMPTY    = 2'd1,
    STS_BAD_FREE = 2'd2
  } sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_INIT,
    ST_ALLOC_UPD,
    ST_ALLOC_WAIT,
    ST_ALLOC_MUL,
    ST_FREE_CHK,
    ST_RESULT
  } fsm_t;

  // Controller -> datapath strobes
  typedef struct packed {
    logic init_start;    // load count, start link and mark sweep
    logic init_step;     // write one link and clear one mark
    logic alloc_start;   // latch the head as the given block
    logic alloc_commit;  // pop: head from link RAM, mark, count down
    logic free_start;    // latch the index, mark RAM read in flight
    logic free_commit;   // push: link write, head, unmark, count up
    logic mult_load;     // capture index * stride
    logic res_load;      // latch result status
    sts_t res_status;
    logic res_alloc;     // result carries index and offset
    logic out_load;      // move result into output register
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic alloc_ok;
    logic free_ok;
    logic sweep_last;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/fbfl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbfl_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/fbfl_ctrl.sv @@
// Command sequencer for the free-list allocator: decodes each accepted beat
// and steps the datapath. Depends on fbfl_pkg.
module fbfl_ctrl
  import fbfl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  output logic       in_stall,
  input  dp_stat_t   dp_stat,
  output dp_cmd_t    dp_cmd
);

  fsm_t state_r, state_nxt;

  // State register; reset starts the mark clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath strobes
  always_comb begin
    state_nxt = state_r;
    dp_cmd    = '0;
    dp_cmd.res_status = STS_OK;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          dp_cmd.res_load = 1'b1;
          case (cmd_t'(in_command))
            CMD_INIT: begin
              dp_cmd.init_start = 1'b1;
              state_nxt = ST_INIT;
            end
            CMD_ALLOC: begin
              if (dp_stat.alloc_ok) begin
                dp_cmd.alloc_start = 1'b1;
                dp_cmd.res_alloc   = 1'b1;
                state_nxt = ST_ALLOC_UPD;
              end else begin
                dp_cmd.res_status = STS_EMPTY;
                state_nxt = ST_RESULT;
              end
            end
            CMD_FREE: begin
              dp_cmd.free_start = 1'b1;
              state_nxt = ST_FREE_CHK;
            end
            default: begin
              state_nxt = ST_RESULT;
            end
          endcase
        end
      end
      // Post-reset pass: clear every in-use mark
      ST_CLEAR: begin
        dp_cmd.init_step = 1'b1;
        if (dp_stat.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_INIT: begin
        dp_cmd.init_step = 1'b1;
        if (dp_stat.sweep_last) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_ALLOC_UPD: begin
        dp_cmd.alloc_commit = 1'b1;
        state_nxt = ST_ALLOC_WAIT;
      end
      // stride pipeline settles after a block_bytes write
      ST_ALLOC_WAIT: begin
        state_nxt = ST_ALLOC_MUL;
      end
      ST_ALLOC_MUL: begin
        dp_cmd.mult_load = 1'b1;
        state_nxt = ST_RESULT;
      end
      // Mark of the freed block is back from the mark RAM
      ST_FREE_CHK: begin
        dp_cmd.res_load = 1'b1;
        if (dp_stat.free_ok) begin
          dp_cmd.free_commit = 1'b1;
        end else begin
          dp_cmd.res_status = STS_BAD_FREE;
        end
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (dp_stat.out_free) begin
          dp_cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/fbfl_dp.sv @@
// Datapath: config registers, list head, free counter, link and in-use mark RAMs,
// stride and offset arithmetic, output register. Depends on fbfl_pkg, fbfl_ram.
module fbfl_dp
  import fbfl_pkg::*;
#(
  parameter int NUM_BLOCKS   = 64,
  parameter int HEADER_BYTES = 24,
  parameter int WORD_BYTES   = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BB_W-1:0]      cfg_wdata,
  input  logic [IDX_W-1:0]     in_block_index,
  input  dp_cmd_t              dp_cmd,
  output dp_stat_t             dp_stat,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [IDX_W-1:0]     out_given_index,
  output logic [OFS_W-1:0]     out_payload_offset,
  output logic [CNT_W-1:0]     out_free_count
);

  // Pool depth is capped by what a block index can name
  localparam int DEPTH = (NUM_BLOCKS < (1 << IDX_W)) ? NUM_BLOCKS : (1 << IDX_W);
  localparam int AW    = $clog2(DEPTH);

  // Round-up divide by WORD_BYTES as reciprocal multiply (exact for x < 2^X_W,
  // word size up to 8)
  localparam int X_W     = BB_W + 1;
  localparam int SHIFT   = X_W + 3;
  localparam int RECIP_W = SHIFT;
  localparam int RECIP   = ((1 << SHIFT) + WORD_BYTES - 1) / WORD_BYTES;
  localparam int PROD_W  = X_W + RECIP_W;
  localparam int STRIDE_W = X_W;
  localparam int MUL_W   = IDX_W + STRIDE_W;
  localparam int SUM_W   = MUL_W + 1;
  localparam int OFS_BIAS = HEADER_BYTES + WORD_BYTES;

  // Config registers
  logic [BB_W-1:0]  bb_r;
  logic [CNT_W-1:0] biu_r;

  // List state
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] sweep_r, sweep_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;

  // Payload registers
  logic [PROD_W-1:0]   prod_r;
  logic [STRIDE_W-1:0] stride_r;
  logic [IDX_W-1:0]    given_r;
  logic [IDX_W-1:0]    idx_r;
  logic [MUL_W-1:0]    mult_r;
  sts_t                res_status_r;
  logic                res_alloc_r;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  sts_t             out_status_r;
  logic [IDX_W-1:0] out_index_r;
  logic [OFS_W-1:0] out_offset_r;
  logic [CNT_W-1:0] out_count_r;

  logic [X_W-1:0]      x_c;
  logic [STRIDE_W-1:0] q_c;
  logic [CNT_W-1:0]    n_c;
  logic [CNT_W-1:0]    sweep_inc;
  logic [IDX_W-1:0]    link_val;
  logic [SUM_W-1:0]    ofs_sum;
  logic [OFS_W-1:0]    ofs_sat;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [IDX_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_rdata;

  logic             mark_we;
  logic [AW-1:0]    mark_waddr;
  logic             mark_wdata;
  logic             mark_rdata;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bb_r  <= BB_W'(8);
      biu_r <= CNT_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_BYTES:   bb_r  <= cfg_wdata;
        CFG_BLOCKS_IN_USE: biu_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stride pipeline, free running: round up, divide, scale, add a word
  assign x_c = {1'b0, bb_r} + X_W'(WORD_BYTES - 1);
  assign q_c = prod_r[PROD_W-1:SHIFT];

  always_ff @(posedge clk) begin
    prod_r   <= PROD_W'(x_c) * PROD_W'(RECIP);
    stride_r <= (q_c + STRIDE_W'(1)) * STRIDE_W'(WORD_BYTES);
  end

  // Sweep helpers: the sweep covers every entry, links chain the first n
  assign n_c       = (biu_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : biu_r;
  assign sweep_inc = sweep_r + CNT_W'(1);
  assign link_val  = (sweep_inc < n_r) ? sweep_inc[IDX_W-1:0] : '0;

  // Link RAM: write from sweep or free, read always at the head
  assign ram_we    = dp_cmd.init_step | dp_cmd.free_commit;
  assign ram_waddr = dp_cmd.init_step ? sweep_r[AW-1:0] : idx_r[AW-1:0];
  assign ram_wdata = dp_cmd.init_step ? link_val : head_r;

  fbfl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // In-use mark RAM: cleared by the sweep, set on pop, cleared on push;
  // read at the incoming block index so the mark is ready in the next cycle
  assign mark_we    = dp_cmd.init_step | dp_cmd.alloc_commit | dp_cmd.free_commit;
  assign mark_waddr = dp_cmd.init_step    ? sweep_r[AW-1:0] :
                      dp_cmd.alloc_commit ? given_r[AW-1:0] : idx_r[AW-1:0];
  assign mark_wdata = dp_cmd.alloc_commit;

  fbfl_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (in_block_index[AW-1:0]),
    .rdata (mark_rdata)
  );

  // List state next values
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    sweep_nxt = sweep_r;
    n_nxt     = n_r;
    if (dp_cmd.init_start) begin
      head_nxt  = '0;
      count_nxt = n_c;
      sweep_nxt = '0;
      n_nxt     = n_c;
    end
    if (dp_cmd.init_step) begin
      sweep_nxt = sweep_inc;
    end
    if (dp_cmd.alloc_commit) begin
      head_nxt  = ram_rdata;
      count_nxt = count_r - CNT_W'(1);
    end
    if (dp_cmd.free_commit) begin
      head_nxt  = idx_r;
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      sweep_r <= '0;
      n_r     <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      sweep_r <= sweep_nxt;
      n_r     <= n_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (dp_cmd.alloc_start) begin
      given_r <= head_r;
    end
    if (dp_cmd.free_start) begin
      idx_r <= in_block_index;
    end
    if (dp_cmd.mult_load) begin
      mult_r <= MUL_W'(given_r) * MUL_W'(stride_r);
    end
    if (dp_cmd.res_load) begin
      res_status_r <= dp_cmd.res_status;
      res_alloc_r  <= dp_cmd.res_alloc;
    end
  end

  // Offset add and saturate
  assign ofs_sum = SUM_W'(mult_r) + SUM_W'(OFS_BIAS);
  assign ofs_sat = (ofs_sum > SUM_W'(OFS_MAX)) ? OFS_MAX : ofs_sum[OFS_W-1:0];

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (dp_cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.out_load) begin
      out_status_r <= res_status_r;
      out_index_r  <= res_alloc_r ? given_r : '0;
      out_offset_r <= res_alloc_r ? ofs_sat : '0;
      out_count_r  <= count_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_given_index    = out_index_r;
  assign out_payload_offset = out_offset_r;
  assign out_free_count     = out_count_r;

  // Status to controller
  assign dp_stat.alloc_ok   = (count_r != '0) && ({1'b0, head_r} < CNT_W'(DEPTH));
  assign dp_stat.free_ok    = ({1'b0, idx_r} < CNT_W'(DEPTH)) && mark_rdata;
  assign dp_stat.sweep_last = (sweep_inc == CNT_W'(DEPTH));
  assign dp_stat.out_free   = !out_valid_r || !out_stall;

endmodule

@@ rtl/fixed_block_free_list_allocator.sv @@
// Fixed-size block allocator over a linked free list; one result beat per command.
// Flow: no-op and failed alloc go straight to the result; free reads the in-use mark;
// alloc reads the link, lets the stride settle, forms index*stride; init writes one
// link and clears one mark per block, D = min(NUM_BLOCKS, 64) blocks. A stalled result
// holds off the next accept. Reset (rst_n, synchronous): list empty, count 0, config
// to defaults, then a sweep of D blocks clears the in-use marks with input stalled.
module fixed_block_free_list_allocator
  import fbfl_pkg::*;
#(
  parameter int NUM_BLOCKS   = 64,
  parameter int HEADER_BYTES = 24,
  parameter int WORD_BYTES   = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BB_W-1:0]      cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_command,
  input  logic [IDX_W-1:0]     in_block_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [IDX_W-1:0]     out_given_index,
  output logic [OFS_W-1:0]     out_payload_offset,
  output logic [CNT_W-1:0]     out_free_count
);

  localparam int DEPTH = (NUM_BLOCKS < (1 << IDX_W)) ? NUM_BLOCKS : (1 << IDX_W);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  fbfl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .dp_stat    (dp_stat),
    .dp_cmd     (dp_cmd)
  );

  fbfl_dp #(
    .NUM_BLOCKS   (NUM_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES),
    .WORD_BYTES   (WORD_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_block_index     (in_block_index),
    .dp_cmd             (dp_cmd),
    .dp_stat            (dp_stat),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_given_index    (out_given_index),
    .out_payload_offset (out_payload_offset),
    .out_free_count     (out_free_count)
  );

`ifndef ASSERT_OFF
  // Free count never exceeds the pool
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_free_count <= CNT_W'(DEPTH)))
    else $error("free count above pool size");

  // Failed commands carry no block
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STS_OK)) |->
      ((out_given_index == '0) && (out_payload_offset == '0)))
    else $error("failed command reports a block");

  // Datapath gets at most one state-changing strobe per cycle
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({dp_cmd.init_start, dp_cmd.init_step, dp_cmd.alloc_start,
              dp_cmd.alloc_commit, dp_cmd.free_start, dp_cmd.free_commit,
              dp_cmd.mult_load, dp_cmd.out_load}))
    else $error("conflicting datapath strobes");

  // A pop always follows an accepted alloc in the next cycle
  a_pop_follows: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.alloc_start |=> (dp_cmd.alloc_commit && in_stall))
    else $error("alloc pop out of sequence");
`endif

endmodule
